// File: rtl/irc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irc_pkg: shared types and constants of the inode reference cache
// Field widths, command and status codes, and the layouts of one table word
// and one result item.
// ----------------------------------------------------------------------------
package irc_pkg;

   localparam int DEVICE_W = 8;
   localparam int INODE_W = 32;
   localparam int SLOT_W = 6;
   localparam int ENTRY_W = 6;
   localparam int STATUS_W = 2;
   localparam int BLOCK_W = 32;
   localparam int COUNT_W = 8;

   localparam int INODES_PER_BLOCK = 8;
   localparam int OFFSET_W = $clog2(INODES_PER_BLOCK);

   localparam int TABLE_ENTRIES_DEFAULT = 64;

   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NULL_RELEASE = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_UNUSED_RELEASE = 2'd3;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // One table word as kept in the entry memory.
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic dirty;
      logic [DEVICE_W-1:0] device;
      logic [INODE_W-1:0] inode;
   } entry_type;

   // One result item.
   typedef struct packed {
      logic [ENTRY_W-1:0] entry;
      logic hit;
      logic [STATUS_W-1:0] status;
      logic fetch_needed;
      logic writeback_needed;
      logic [BLOCK_W-1:0] disk_block;
      logic [OFFSET_W-1:0] block_offset;
      logic [COUNT_W-1:0] count_after;
   } rsp_type;

endpackage

// File: rtl/irc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irc_if: request and response channels of the inode reference cache
// Valid/ready channels; an item moves on a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface irc_req_if;
   logic valid;
   logic ready;
   logic command;
   logic [irc_pkg::DEVICE_W-1:0] device;
   logic [irc_pkg::INODE_W-1:0] inode_number;
   logic [irc_pkg::SLOT_W-1:0] slot;
   logic slot_present;
   logic modified;

   modport source (
      output valid, command, device, inode_number, slot, slot_present, modified,
      input ready
   );
   modport sink (
      input valid, command, device, inode_number, slot, slot_present, modified,
      output ready
   );
endinterface

interface irc_rsp_if;
   logic valid;
   logic ready;
   logic [irc_pkg::ENTRY_W-1:0] entry;
   logic hit;
   logic [irc_pkg::STATUS_W-1:0] status;
   logic fetch_needed;
   logic writeback_needed;
   logic [irc_pkg::BLOCK_W-1:0] disk_block;
   logic [irc_pkg::OFFSET_W-1:0] block_offset;
   logic [irc_pkg::COUNT_W-1:0] count_after;

   modport source (
      output valid, entry, hit, status, fetch_needed, writeback_needed,
      disk_block, block_offset, count_after,
      input ready
   );
   modport sink (
      input valid, entry, hit, status, fetch_needed, writeback_needed,
      disk_block, block_offset, count_after,
      output ready
   );
endinterface

// File: rtl/irc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irc_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module irc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/inode_reference_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inode_reference_cache: reference-counted table of cached inode entries
// A get finds or claims a table entry for a device and inode number; a put
// releases one and asks for a write-back when a dirty entry becomes unused.
//
// Channels: req_port takes one command item (get or put), rsp_port returns
// exactly one result item for it. csr_write_enable/csr_write_data load the
// first block of the on-disk inode table; write it only while idle.
// Flow: a get walks the entry memory one entry per cycle through a single
// comparator, stopping at the first live match. A put reads its entry once
// if its slot is in range; a null release reads no entry. The block works on
// one item at a time and raises req_port.ready in the same cycle as it
// presents the result from the output register. A stalled receiver holds
// back only the following result.
// Reset: a clearing pass over the entry memory zeroes every reference
// count and dirty mark; no item is accepted during it. Configuration writes
// are taken during it as well.
// ----------------------------------------------------------------------------
module inode_reference_cache #(
   parameter int TABLE_ENTRIES = irc_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   irc_req_if.sink                      req_port,
   irc_rsp_if.source                    rsp_port,
   input  logic                         csr_write_enable,
   input  logic [irc_pkg::BLOCK_W-1:0]  csr_write_data
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = IDX_W + 1;
   localparam int WORD_W = $bits(irc_pkg::entry_type);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
   localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(TABLE_ENTRIES);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE = 3'd1;
   localparam logic [2:0] ST_SCAN = 3'd2;
   localparam logic [2:0] ST_PUT_READ = 3'd3;
   localparam logic [2:0] ST_PUT_LATCH = 3'd4;
   localparam logic [2:0] ST_COMMIT = 3'd5;
   localparam logic [2:0] ST_DONE = 3'd6;

   localparam logic [1:0] OP_HIT = 2'd0;
   localparam logic [1:0] OP_ALLOC = 2'd1;
   localparam logic [1:0] OP_PUT = 2'd2;

   function automatic logic [irc_pkg::ENTRY_W-1:0] entry_of(input logic [IDX_W-1:0] idx);
      logic [31:0] wide;
      wide = 32'(idx);
      return wide[irc_pkg::ENTRY_W-1:0];
   endfunction

   logic [2:0]                          state_ff, state_in;
   logic [IDX_W-1:0]                    clr_ff, clr_in;
   logic [CNT_W-1:0]                    scan_ff, scan_in;
   logic                                chk_valid_ff, chk_valid_in;
   logic [IDX_W-1:0]                    chk_idx_ff, chk_idx_in;
   logic                                free_found_ff, free_found_in;
   logic [IDX_W-1:0]                    free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]                    tgt_ff, tgt_in;
   logic [1:0]                          op_ff, op_in;
   irc_pkg::entry_type                  word_ff, word_in;
   logic [irc_pkg::DEVICE_W-1:0]        dev_ff, dev_in;
   logic [irc_pkg::INODE_W-1:0]         ino_ff, ino_in;
   logic [irc_pkg::INODE_W-1:0]         k_ff, k_in;
   logic [irc_pkg::SLOT_W-1:0]          slot_ff, slot_in;
   logic                                modified_ff, modified_in;
   irc_pkg::rsp_type                    res_ff, res_in;
   irc_pkg::rsp_type                    rsp_ff, rsp_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [irc_pkg::BLOCK_W-1:0]         start_ff, start_in;

   logic                                ram_wr_en;
   logic [IDX_W-1:0]                    ram_wr_addr;
   irc_pkg::entry_type                  ram_wr_word;
   logic                                ram_rd_en;
   logic [IDX_W-1:0]                    ram_rd_addr;
   logic [WORD_W-1:0]                   ram_rd_data;
   irc_pkg::entry_type                  rd_word;

   logic                                accept;
   logic                                rsp_free;
   logic                                match;
   logic                                slot_in_range;
   logic [IDX_W-1:0]                    slot_idx;
   logic [irc_pkg::BLOCK_W-1:0]         block_sum;
   logic [irc_pkg::COUNT_W-1:0]         count_dec;
   logic                                dirty_new;

   irc_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_word),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_word = irc_pkg::entry_type'(ram_rd_data);

   assign accept = req_port.valid && req_port.ready;
   assign rsp_free = !rsp_valid_ff || rsp_port.ready;

   // The one comparator that every scan step reuses.
   assign match = (rd_word.count != '0) && (rd_word.device == dev_ff) &&
                  (rd_word.inode == ino_ff);

   assign slot_in_range = 32'(slot_ff) < TABLE_ENTRIES;
   assign slot_idx = IDX_W'(slot_ff);
   assign block_sum = (k_ff >> irc_pkg::OFFSET_W) + start_ff;
   assign count_dec = word_ff.count - 8'd1;
   assign dirty_new = word_ff.dirty | modified_ff;

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      scan_in = scan_ff;
      chk_valid_in = 1'b0;
      chk_idx_in = chk_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in = free_idx_ff;
      tgt_in = tgt_ff;
      op_in = op_ff;
      word_in = word_ff;
      dev_in = dev_ff;
      ino_in = ino_ff;
      k_in = k_ff;
      slot_in = slot_ff;
      modified_in = modified_ff;
      res_in = res_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      start_in = start_ff;

      ram_wr_en = 1'b0;
      ram_wr_addr = tgt_ff;
      ram_wr_word = '0;
      ram_rd_en = 1'b0;
      ram_rd_addr = scan_ff[IDX_W-1:0];

      if (csr_write_enable) begin
         start_in = csr_write_data;
      end

      if (rsp_valid_ff && rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en = 1'b1;
            ram_wr_addr = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (accept) begin
               dev_in = req_port.device;
               ino_in = req_port.inode_number;
               k_in = req_port.inode_number - 32'd1;
               slot_in = req_port.slot;
               modified_in = req_port.modified;
               res_in = '0;
               scan_in = '0;
               free_found_in = 1'b0;
               if (req_port.command == irc_pkg::CMD_GET) begin
                  state_in = ST_SCAN;
               end else if (!req_port.slot_present) begin
                  res_in.status = irc_pkg::STATUS_NULL_RELEASE;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_PUT_READ;
               end
            end
         end

         ST_SCAN: begin
            // Read entry scan_ff while checking the entry read the cycle before.
            if (scan_ff < SCAN_END) begin
               ram_rd_en = 1'b1;
               chk_valid_in = 1'b1;
               chk_idx_in = scan_ff[IDX_W-1:0];
               scan_in = scan_ff + 1'b1;
            end
            if (chk_valid_ff) begin
               if (match) begin
                  word_in = rd_word;
                  tgt_in = chk_idx_ff;
                  op_in = OP_HIT;
                  chk_valid_in = 1'b0;
                  state_in = ST_COMMIT;
               end else begin
                  if (!free_found_ff && rd_word.count == '0) begin
                     free_found_in = 1'b1;
                     free_idx_in = chk_idx_ff;
                  end
                  if (chk_idx_ff == LAST_IDX) begin
                     chk_valid_in = 1'b0;
                     if (free_found_ff) begin
                        tgt_in = free_idx_ff;
                        op_in = OP_ALLOC;
                        state_in = ST_COMMIT;
                     end else if (rd_word.count == '0) begin
                        tgt_in = chk_idx_ff;
                        op_in = OP_ALLOC;
                        state_in = ST_COMMIT;
                     end else begin
                        res_in.status = irc_pkg::STATUS_FULL;
                        state_in = ST_DONE;
                     end
                  end
               end
            end
         end

         ST_PUT_READ: begin
            res_in.entry = slot_ff;
            if (slot_in_range) begin
               ram_rd_en = 1'b1;
               ram_rd_addr = slot_idx;
               state_in = ST_PUT_LATCH;
            end else begin
               res_in.status = irc_pkg::STATUS_UNUSED_RELEASE;
               state_in = ST_DONE;
            end
         end

         ST_PUT_LATCH: begin
            word_in = rd_word;
            k_in = rd_word.inode - 32'd1;
            tgt_in = slot_idx;
            op_in = OP_PUT;
            state_in = ST_COMMIT;
         end

         ST_COMMIT: begin
            state_in = ST_DONE;
            case (op_ff)
               OP_HIT: begin
                  ram_wr_en = 1'b1;
                  ram_wr_word = word_ff;
                  if (word_ff.count != irc_pkg::COUNT_MAX) begin
                     ram_wr_word.count = word_ff.count + 8'd1;
                  end
                  res_in.entry = entry_of(tgt_ff);
                  res_in.hit = 1'b1;
                  res_in.count_after = ram_wr_word.count;
               end
               OP_ALLOC: begin
                  ram_wr_en = 1'b1;
                  ram_wr_word.count = 8'd1;
                  ram_wr_word.dirty = 1'b0;
                  ram_wr_word.device = dev_ff;
                  ram_wr_word.inode = ino_ff;
                  res_in.entry = entry_of(tgt_ff);
                  res_in.fetch_needed = 1'b1;
                  res_in.disk_block = block_sum;
                  res_in.block_offset = k_ff[irc_pkg::OFFSET_W-1:0];
                  res_in.count_after = 8'd1;
               end
               default: begin
                  if (word_ff.count == '0) begin
                     res_in.status = irc_pkg::STATUS_UNUSED_RELEASE;
                  end else begin
                     ram_wr_en = 1'b1;
                     ram_wr_word = word_ff;
                     ram_wr_word.count = count_dec;
                     ram_wr_word.dirty = dirty_new;
                     res_in.count_after = count_dec;
                     if (count_dec == '0 && dirty_new) begin
                        res_in.writeback_needed = 1'b1;
                        res_in.disk_block = block_sum;
                        res_in.block_offset = k_ff[irc_pkg::OFFSET_W-1:0];
                     end
                  end
               end
            endcase
         end

         ST_DONE: begin
            if (rsp_free) begin
               rsp_in = res_ff;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         start_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         start_ff <= start_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      chk_idx_ff <= chk_idx_in;
      free_found_ff <= free_found_in;
      free_idx_ff <= free_idx_in;
      tgt_ff <= tgt_in;
      op_ff <= op_in;
      word_ff <= word_in;
      dev_ff <= dev_in;
      ino_ff <= ino_in;
      k_ff <= k_in;
      slot_ff <= slot_in;
      modified_ff <= modified_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   assign req_port.ready = (state_ff == ST_IDLE);

   assign rsp_port.valid = rsp_valid_ff;
   assign rsp_port.entry = rsp_ff.entry;
   assign rsp_port.hit = rsp_ff.hit;
   assign rsp_port.status = rsp_ff.status;
   assign rsp_port.fetch_needed = rsp_ff.fetch_needed;
   assign rsp_port.writeback_needed = rsp_ff.writeback_needed;
   assign rsp_port.disk_block = rsp_ff.disk_block;
   assign rsp_port.block_offset = rsp_ff.block_offset;
   assign rsp_port.count_after = rsp_ff.count_after;

   // No result can appear before the clearing pass has finished.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_valid_ff)
      else $error("result item presented during the clearing pass");

   // An accepted item keeps the block busy for at least the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_port.ready)
      else $error("request taken twice in consecutive cycles");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_port.valid && rsp_port.hit) |->
         (rsp_port.count_after != '0 && rsp_port.status == irc_pkg::STATUS_OK &&
          !rsp_port.fetch_needed && !rsp_port.writeback_needed))
      else $error("hit result with inconsistent fields");

   assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid |-> !(rsp_port.fetch_needed && rsp_port.writeback_needed))
      else $error("fetch and write-back requested together");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_port.valid && rsp_port.status != irc_pkg::STATUS_OK) |->
         (!rsp_port.fetch_needed && !rsp_port.writeback_needed &&
          rsp_port.count_after == '0))
      else $error("error result requests a disk transfer or holds a count");

endmodule
